FILE: rtl/three_point_angle_3d_defines.svh
// ----------------------------------------------------------------------------
// three_point_angle_3d assertion macros
// Shared concurrent assertion forms, sampled on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_POINT_ANGLE_3D_DEFINES_SVH
`define THREE_POINT_ANGLE_3D_DEFINES_SVH

// same-cycle implication
`define TPA3_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPA3_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tpa3_pkg.sv
// ----------------------------------------------------------------------------
// tpa3_pkg
// Types, widths and constants shared by the three point angle blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpa3_pkg;

    localparam int COORD_W      = 24;
    localparam int NUM_COORDS   = 9;
    localparam int IN_DATA_W    = COORD_W * NUM_COORDS;
    localparam int SPACING_W    = 16;
    localparam int ANGLE_W      = 16;
    localparam int ARM_W        = 31;
    localparam int ACC_FRAC     = 24;
    localparam int ANGLE_Z_W    = 34;
    localparam int CORDIC_W     = 46;
    localparam int CORDIC_STEPS = 30;
    localparam int ISQRT_STEPS  = 31;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd4096;
    localparam longint RAD_TO_DEG_Q24 = 64'd961263669;

    typedef enum logic [1:0] {
        CFG_SPACING_X = 2'd0,
        CFG_SPACING_Y = 2'd1,
        CFG_SPACING_Z = 2'd2
    } cfg_idx_t;

    typedef logic signed [ARM_W-1:0] arm_t;

    typedef struct packed {
        arm_t [2:0] a;
        arm_t [2:0] b;
        logic       degen;
    } arm_pair_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [ANGLE_Z_W-1:0] step_angle(input int unsigned i);
        logic signed [ANGLE_Z_W-1:0] r;
        unique case (i)
            0:  r = 34'sd754974720;
            1:  r = 34'sd445687602;
            2:  r = 34'sd235489088;
            3:  r = 34'sd119537938;
            4:  r = 34'sd60000934;
            5:  r = 34'sd30029717;
            6:  r = 34'sd15018523;
            7:  r = 34'sd7509720;
            8:  r = 34'sd3754917;
            9:  r = 34'sd1877466;
            10: r = 34'sd938734;
            11: r = 34'sd469367;
            default: r = ANGLE_Z_W'(RAD_TO_DEG_Q24 >> i);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/tpa3_front.sv
// ----------------------------------------------------------------------------
// tpa3_front
// Accepts point triples, forms and scales both arms, flags zero arms and
// normalizes each arm to 31 bit signed components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpa3_front import tpa3_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [SPACING_W-1:0] spacing_x,
    input  logic [SPACING_W-1:0] spacing_y,
    input  logic [SPACING_W-1:0] spacing_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output arm_pair_t            out_data
);

    logic                en;
    logic [SPACING_W-1:0] sp [3];

    logic signed [40:0] sc_next [6];
    logic signed [40:0] sc_reg  [6];
    logic               f0_vld_reg;

    logic [39:0] mag_next [6];
    logic [39:0] mag_reg  [6];
    logic        neg_reg  [6];
    logic        f1_degen_next;
    logic        f1_degen_reg;
    logic        f1_vld_reg;

    arm_pair_t   arm_next;
    arm_pair_t   arm_reg;
    logic        f2_vld_reg;

    assign sp[0] = spacing_x;
    assign sp[1] = spacing_y;
    assign sp[2] = spacing_z;

    assign en       = !f2_vld_reg || out_ready;
    assign s_tready = en;
    assign out_valid = f2_vld_reg;
    assign out_data  = arm_reg;

    // arm differences times spacing
    always_comb begin
        logic signed [COORD_W-1:0] v, e1, e2;
        logic signed [COORD_W:0]   d1, d2;
        logic signed [SPACING_W:0] s;
        logic signed [41:0]        p1, p2;
        for (int k = 0; k < 3; k++) begin
            v  = $signed(s_tdata[COORD_W*k +: COORD_W]);
            e1 = $signed(s_tdata[COORD_W*(k+3) +: COORD_W]);
            e2 = $signed(s_tdata[COORD_W*(k+6) +: COORD_W]);
            d1 = $signed({e1[COORD_W-1], e1}) - $signed({v[COORD_W-1], v});
            d2 = $signed({e2[COORD_W-1], e2}) - $signed({v[COORD_W-1], v});
            s  = $signed({1'b0, sp[k]});
            p1 = d1 * s;
            p2 = d2 * s;
            sc_next[k]   = p1[40:0];
            sc_next[k+3] = p2[40:0];
        end
    end

    // magnitudes and zero arm check
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            mag_next[k] = sc_reg[k][40] ? 40'(-sc_reg[k]) : 40'(sc_reg[k]);
        end
        f1_degen_next = ((sc_reg[0] == '0) && (sc_reg[1] == '0) && (sc_reg[2] == '0)) ||
                        ((sc_reg[3] == '0) && (sc_reg[4] == '0) && (sc_reg[5] == '0));
    end

    // common shift per arm until every component is below 2^30
    always_comb begin
        logic [39:0]     orv;
        logic [3:0]      sh;
        logic [39:0]     m;
        logic [ARM_W-1:0] r;
        arm_next = '0;
        for (int g = 0; g < 2; g++) begin
            orv = mag_reg[3*g] | mag_reg[3*g+1] | mag_reg[3*g+2];
            sh  = '0;
            for (int j = 0; j < 10; j++) begin
                if (orv[30+j]) begin
                    sh = 4'(j + 1);
                end
            end
            for (int k = 0; k < 3; k++) begin
                m = mag_reg[3*g+k] >> sh;
                r = neg_reg[3*g+k] ? -{1'b0, m[29:0]} : {1'b0, m[29:0]};
                if (g == 0) begin
                    arm_next.a[k] = $signed(r);
                end else begin
                    arm_next.b[k] = $signed(r);
                end
            end
        end
        arm_next.degen = f1_degen_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end else if (en) begin
            f0_vld_reg <= s_tvalid;
            f1_vld_reg <= f0_vld_reg;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                sc_reg[k]  <= sc_next[k];
                mag_reg[k] <= mag_next[k];
                neg_reg[k] <= sc_reg[k][40];
            end
            f1_degen_reg <= f1_degen_next;
            arm_reg      <= arm_next;
        end
    end

endmodule

FILE: rtl/tpa3_queue.sv
// ----------------------------------------------------------------------------
// tpa3_queue
// Short register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpa3_queue import tpa3_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  arm_pair_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output arm_pair_t out_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    arm_pair_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;
    logic [PTR_W:0]   cnt_next;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/tpa3_back.sv
// ----------------------------------------------------------------------------
// tpa3_back
// Cross and dot products, normalization, pipelined integer square root and
// a 30 stage vectoring CORDIC giving the angle in degrees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpa3_back import tpa3_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  arm_pair_t          in_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ANGLE_W-1:0] m_tdata,
    output logic [0:0]         m_tuser
);

    localparam logic signed [ANGLE_Z_W-1:0] Z_LIMIT = ANGLE_Z_W'(180) << ACC_FRAC;
    localparam logic signed [ANGLE_Z_W-1:0] Z_RIGHT = ANGLE_Z_W'(90) << ACC_FRAC;
    localparam logic [ANGLE_Z_W-1:0] ROUND_HALF =
        ANGLE_Z_W'(1) << (ACC_FRAC - 1 - ANGLE_FRAC_BITS);
    localparam int OUT_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

    logic en;
    logic [4:0] b_vld_reg;

    // products
    logic signed [61:0] p_reg [9];
    logic               b0_degen_reg;
    // cross and dot
    logic signed [62:0] cd_next [4];
    logic signed [62:0] cd_reg  [4];
    logic               b1_degen_reg;
    // magnitudes
    logic [61:0] cm_next [4];
    logic [61:0] cm_reg  [4];
    logic        dot_neg_reg;
    logic        b2_degen_reg;
    // normalized
    logic [29:0]      cr_next [3];
    logic [29:0]      cr_reg  [3];
    arm_t             dot_next;
    arm_t             dot3_reg;
    logic             b3_degen_reg;
    // squares
    logic [59:0] sq_reg [3];
    arm_t        dot4_reg;
    logic        b4_degen_reg;

    // square root pipeline, entry 0 holds the sum of squares
    logic [61:0] isq_n_reg   [ISQRT_STEPS+1];
    logic [61:0] isq_r_reg   [ISQRT_STEPS+1];
    arm_t        isq_dot_reg [ISQRT_STEPS+1];
    logic        isq_dg_reg  [ISQRT_STEPS+1];
    logic        isq_vld_reg [ISQRT_STEPS+1];

    // cordic pipeline, entry 0 holds the pre-rotated vector
    logic signed [CORDIC_W-1:0]  cor_x_reg   [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0]  cor_y_reg   [CORDIC_STEPS+1];
    logic signed [ANGLE_Z_W-1:0] cor_z_reg   [CORDIC_STEPS+1];
    logic                        cor_dg_reg  [CORDIC_STEPS+1];
    logic                        cor_vld_reg [CORDIC_STEPS+1];

    logic signed [CORDIC_W-1:0]  cor_pre_x;
    logic signed [CORDIC_W-1:0]  cor_pre_y;
    logic signed [ANGLE_Z_W-1:0] cor_pre_z;

    logic               m_tvalid_reg;
    logic [ANGLE_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign in_ready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        cd_next[0] = p_reg[0] - p_reg[1];
        cd_next[1] = p_reg[2] - p_reg[3];
        cd_next[2] = p_reg[4] - p_reg[5];
        cd_next[3] = p_reg[6] + p_reg[7] + p_reg[8];
        for (int k = 0; k < 4; k++) begin
            cm_next[k] = cd_reg[k][62] ? 62'(-cd_reg[k]) : 62'(cd_reg[k]);
        end
    end

    always_comb begin
        logic [61:0] orv;
        logic [5:0]  sh;
        logic [61:0] m;
        orv = cm_reg[0] | cm_reg[1] | cm_reg[2] | cm_reg[3];
        sh  = '0;
        for (int j = 0; j < 32; j++) begin
            if (orv[30+j]) begin
                sh = 6'(j + 1);
            end
        end
        for (int k = 0; k < 3; k++) begin
            m = cm_reg[k] >> sh;
            cr_next[k] = m[29:0];
        end
        m = cm_reg[3] >> sh;
        dot_next = dot_neg_reg ? $signed(-{1'b0, m[29:0]}) : $signed({1'b0, m[29:0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= '0;
        end else if (en) begin
            b_vld_reg <= {b_vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= $signed(in_data.a[1]) * $signed(in_data.b[2]);
            p_reg[1] <= $signed(in_data.a[2]) * $signed(in_data.b[1]);
            p_reg[2] <= $signed(in_data.a[2]) * $signed(in_data.b[0]);
            p_reg[3] <= $signed(in_data.a[0]) * $signed(in_data.b[2]);
            p_reg[4] <= $signed(in_data.a[0]) * $signed(in_data.b[1]);
            p_reg[5] <= $signed(in_data.a[1]) * $signed(in_data.b[0]);
            p_reg[6] <= $signed(in_data.a[0]) * $signed(in_data.b[0]);
            p_reg[7] <= $signed(in_data.a[1]) * $signed(in_data.b[1]);
            p_reg[8] <= $signed(in_data.a[2]) * $signed(in_data.b[2]);
            b0_degen_reg <= in_data.degen;
            for (int k = 0; k < 4; k++) begin
                cd_reg[k] <= cd_next[k];
                cm_reg[k] <= cm_next[k];
            end
            b1_degen_reg <= b0_degen_reg;
            dot_neg_reg  <= cd_reg[3][62];
            b2_degen_reg <= b1_degen_reg;
            for (int k = 0; k < 3; k++) begin
                cr_reg[k] <= cr_next[k];
                sq_reg[k] <= cr_reg[k] * cr_reg[k];
            end
            dot3_reg     <= dot_next;
            b3_degen_reg <= b2_degen_reg;
            dot4_reg     <= dot3_reg;
            b4_degen_reg <= b3_degen_reg;
            isq_n_reg[0]   <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
            isq_r_reg[0]   <= '0;
            isq_dot_reg[0] <= dot4_reg;
            isq_dg_reg[0]  <= b4_degen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            isq_vld_reg[0] <= 1'b0;
        end else if (en) begin
            isq_vld_reg[0] <= b_vld_reg[4];
        end
    end

    for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_isqrt
        localparam logic [61:0] BIT = 62'(1) << (60 - 2*k);
        logic [62:0] t_next;
        logic [61:0] n_next;
        logic [61:0] r_next;
        always_comb begin
            t_next = {1'b0, isq_r_reg[k]} + {1'b0, BIT};
            if ({1'b0, isq_n_reg[k]} >= t_next) begin
                n_next = isq_n_reg[k] - t_next[61:0];
                r_next = (isq_r_reg[k] >> 1) + BIT;
            end else begin
                n_next = isq_n_reg[k];
                r_next = isq_r_reg[k] >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                isq_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                isq_vld_reg[k+1] <= isq_vld_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                isq_n_reg[k+1]   <= n_next;
                isq_r_reg[k+1]   <= r_next;
                isq_dot_reg[k+1] <= isq_dot_reg[k];
                isq_dg_reg[k+1]  <= isq_dg_reg[k];
            end
        end
    end

    // left half plane is rotated by 90 degrees first
    always_comb begin : pre_rot
        logic signed [CORDIC_W-1:0] x0, y0;
        arm_t                       d;
        d  = isq_dot_reg[ISQRT_STEPS];
        x0 = $signed({{(CORDIC_W-ARM_W-10){d[ARM_W-1]}}, d, 10'b0});
        y0 = $signed({{(CORDIC_W-41){1'b0}}, isq_r_reg[ISQRT_STEPS][30:0], 10'b0});
        cor_pre_x = x0;
        cor_pre_y = y0;
        cor_pre_z = '0;
        if (d[ARM_W-1]) begin
            cor_pre_x = y0;
            cor_pre_y = -x0;
            cor_pre_z = Z_RIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cor_vld_reg[0] <= 1'b0;
        end else if (en) begin
            cor_vld_reg[0] <= isq_vld_reg[ISQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cor_x_reg[0]  <= cor_pre_x;
            cor_y_reg[0]  <= cor_pre_y;
            cor_z_reg[0]  <= cor_pre_z;
            cor_dg_reg[0] <= isq_dg_reg[ISQRT_STEPS];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        localparam logic signed [ANGLE_Z_W-1:0] ANG = step_angle(i);
        logic signed [CORDIC_W-1:0]  x_next, y_next, dx, dy;
        logic signed [ANGLE_Z_W-1:0] z_next;
        always_comb begin
            dx = cor_y_reg[i] >>> i;
            dy = cor_x_reg[i] >>> i;
            if (!cor_y_reg[i][CORDIC_W-1]) begin
                x_next = cor_x_reg[i] + dx;
                y_next = cor_y_reg[i] - dy;
                z_next = cor_z_reg[i] + ANG;
            end else begin
                x_next = cor_x_reg[i] - dx;
                y_next = cor_y_reg[i] + dy;
                z_next = cor_z_reg[i] - ANG;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cor_vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                cor_vld_reg[i+1] <= cor_vld_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                cor_x_reg[i+1]  <= x_next;
                cor_y_reg[i+1]  <= y_next;
                cor_z_reg[i+1]  <= z_next;
                cor_dg_reg[i+1] <= cor_dg_reg[i];
            end
        end
    end

    // clamp, round half up, saturate
    logic [ANGLE_W-1:0] angle_next;
    always_comb begin
        logic signed [ANGLE_Z_W-1:0] zc;
        logic [ANGLE_Z_W-1:0]        q;
        zc = cor_z_reg[CORDIC_STEPS];
        if (zc[ANGLE_Z_W-1]) begin
            zc = '0;
        end else if (zc > Z_LIMIT) begin
            zc = Z_LIMIT;
        end
        q = ($unsigned(zc) + ROUND_HALF) >> OUT_SHIFT;
        if (cor_dg_reg[CORDIC_STEPS]) begin
            angle_next = '0;
        end else if (q > ANGLE_Z_W'(16'hFFFF)) begin
            angle_next = '1;
        end else begin
            angle_next = q[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= cor_vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= angle_next;
            m_tuser_reg <= cor_dg_reg[CORDIC_STEPS];
        end
    end

endmodule

FILE: rtl/three_point_angle_3d.sv
// ----------------------------------------------------------------------------
// three_point_angle_3d
// Angle at a 3D vertex between two arms, with per-axis voxel spacing.
// ----------------------------------------------------------------------------
// Takes one transaction per clock: a vertex and two end points (signed Q16.8)
// and returns the angle between the arms in unsigned degrees with
// ANGLE_FRAC_BITS fraction bits, plus a flag in tuser when either arm has zero
// scaled length (angle then reads 0). Without back pressure a transaction
// passes 3 front stages, one queue slot, 6 product and normalize stages, 31
// square root stages, 1 pre-rotation, 30 CORDIC stages and the output
// register. Sustained rate is one transaction per clock unless the result
// side stalls, set by the fully pipelined square root and CORDIC. Spacing
// registers may be written only while no transaction is in flight.
`timescale 1ns / 1ps

`include "three_point_angle_3d_defines.svh"

module three_point_angle_3d import tpa3_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // vertex_x, vertex_y, vertex_z, end1_x, end1_y, end1_z, end2_x, end2_y, end2_z
    input  logic [IN_DATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // angle_deg
    output logic [ANGLE_W-1:0]   m_tdata,
    // degenerate
    output logic [0:0]           m_tuser,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [SPACING_W-1:0] cfg_wdata
);

    localparam int MAX_ANGLE_RAW = 180 << ANGLE_FRAC_BITS;
    localparam int MAX_ANGLE     = (MAX_ANGLE_RAW > 65535) ? 65535 : MAX_ANGLE_RAW;

    logic [SPACING_W-1:0] spacing_x_reg;
    logic [SPACING_W-1:0] spacing_y_reg;
    logic [SPACING_W-1:0] spacing_z_reg;

    logic      fr_valid, fr_ready;
    arm_pair_t fr_data;
    logic      bk_valid, bk_ready;
    arm_pair_t bk_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_x_reg <= SPACING_RESET;
            spacing_y_reg <= SPACING_RESET;
            spacing_z_reg <= SPACING_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SPACING_X: spacing_x_reg <= cfg_wdata;
                CFG_SPACING_Y: spacing_y_reg <= cfg_wdata;
                CFG_SPACING_Z: spacing_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tpa3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .spacing_x (spacing_x_reg),
        .spacing_y (spacing_y_reg),
        .spacing_z (spacing_z_reg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_data  (fr_data)
    );

    tpa3_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_data)
    );

    tpa3_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (bk_valid),
        .in_ready (bk_ready),
        .in_data  (bk_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `TPA3_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser[0], m_tdata == '0, "degenerate angle not zero")
    `TPA3_ASSERT_IMP(a_angle_range, m_tvalid, m_tdata <= ANGLE_W'(MAX_ANGLE), "angle above 180")
    `TPA3_ASSERT_NXT(a_cfg_x, cfg_wr_en && (cfg_index == CFG_SPACING_X), spacing_x_reg == $past(cfg_wdata), "spacing_x not written")

endmodule

FILE: tb/tb_three_point_angle_3d.sv
// ----------------------------------------------------------------------------
// tb_three_point_angle_3d
// Self-checking testbench for the 3D three point angle block.
// ----------------------------------------------------------------------------
// Drives point triples in bursts with random gaps, stalls the result side on
// its own pattern and once for a long stretch, and compares every result
// with a bit-exact fixed-point angle predictor. Spacing registers are
// changed between phases while the pipeline is empty.
`timescale 1ns / 1ps

module tb_three_point_angle_3d;
    import tpa3_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int DRAIN_CYCLES = 90;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam longint MAG30 = 64'd1 << 30;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic               degen;
    } angle_res_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [ANGLE_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [1:0]           cfg_index = '0;
    logic [SPACING_W-1:0] cfg_wdata = '0;

    angle_res_t angle_q[$];
    longint     spacing[3];
    int         fail_count = 0;
    int         sent_count = 0;
    int         result_count = 0;
    int         degen_count = 0;
    int         burst_left = 0;
    int         hold_cycles = 0;
    int         cycle_count = 0;

    three_point_angle_3d #(.ANGLE_FRAC_BITS(FRAC_BITS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint mag_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v) >>> s);
    endfunction

    function automatic void reduce_vec(ref longint v[4], input int n);
        longint m;
        int s;
        m = 0;
        s = 0;
        for (int i = 0; i < n; i++) begin
            if ((v[i] < 0 ? -v[i] : v[i]) > m) m = v[i] < 0 ? -v[i] : v[i];
        end
        while ((m >>> s) >= MAG30) s++;
        for (int i = 0; i < n; i++) v[i] = mag_shift(v[i], s);
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic angle_res_t predict_angle(logic [IN_DATA_W-1:0] d);
        longint a[4], b[4], cd[4];
        longint v, x, y, z, dx, dy, t, q;
        longint unsigned sq;
        angle_res_t r;
        for (int k = 0; k < 3; k++) begin
            v = longint'($signed(d[COORD_W*k +: COORD_W]));
            a[k] = (longint'($signed(d[COORD_W*(3+k) +: COORD_W])) - v) * spacing[k];
            b[k] = (longint'($signed(d[COORD_W*(6+k) +: COORD_W])) - v) * spacing[k];
        end
        a[3] = 0;
        b[3] = 0;
        if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
            r.angle = '0;
            r.degen = 1'b1;
            return r;
        end
        reduce_vec(a, 3);
        reduce_vec(b, 3);
        cd[0] = a[1] * b[2] - a[2] * b[1];
        cd[1] = a[2] * b[0] - a[0] * b[2];
        cd[2] = a[0] * b[1] - a[1] * b[0];
        cd[3] = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        reduce_vec(cd, 4);
        sq = longint'(cd[0] * cd[0]) + longint'(cd[1] * cd[1]) + longint'(cd[2] * cd[2]);
        x = cd[3] * 1024;
        y = isqrt(sq) * 1024;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = longint'(90) << ACC_FRAC;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += longint'(step_angle(i));
            end else begin
                x -= dx;
                y += dy;
                z -= longint'(step_angle(i));
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(180) << ACC_FRAC)) z = longint'(180) << ACC_FRAC;
        q = (z + (longint'(1) << (ACC_FRAC - 1 - FRAC_BITS))) >>> (ACC_FRAC - FRAC_BITS);
        if (q > 65535) q = 65535;
        r.angle = q[ANGLE_W-1:0];
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        fail_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        angle_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (angle_q.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                e = angle_q.pop_front();
                if (m_tdata !== e.angle) report_mismatch("angle_deg", m_tdata, e.angle);
                if (m_tuser[0] !== e.degen) report_mismatch("degenerate", m_tuser[0], e.degen);
                if (e.degen) degen_count++;
            end
            result_count++;
        end
    end

    // receiver stall pattern, plus long hold-off when requested
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (cycle_count[9:7] == 3'd5) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("three_point_angle_3d test failed");
            $finish;
        end
    end

    task automatic send_item(logic [IN_DATA_W-1:0] d);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        angle_q = {angle_q, predict_angle(d)};
        sent_count++;
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (angle_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_spacing(logic [1:0] idx, logic [SPACING_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx != CFG_UNUSED) spacing[idx] = longint'(val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_spacing(logic [SPACING_W-1:0] sx, logic [SPACING_W-1:0] sy,
                               logic [SPACING_W-1:0] sz);
        wait_idle();
        write_spacing(CFG_SPACING_X, sx);
        write_spacing(CFG_SPACING_Y, sy);
        write_spacing(CFG_SPACING_Z, sz);
    endtask

    function automatic logic [IN_DATA_W-1:0] pack_pts(int c[9]);
        logic [IN_DATA_W-1:0] d;
        for (int k = 0; k < 9; k++) d[COORD_W*k +: COORD_W] = c[k][COORD_W-1:0];
        return d;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_item();
        int c[9];
        int kind, span;
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(0, 22);
        for (int k = 0; k < 3; k++) c[k] = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
        for (int k = 3; k < 9; k++) begin
            if (kind < 2) c[k] = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
            else c[k] = c[k % 3] + $signed($urandom_range(0, 2 * span)) - span;
            if (c[k] > 8388607) c[k] = 8388607;
            if (c[k] < -8388608) c[k] = -8388608;
        end
        if (kind == 2) for (int k = 3; k < 6; k++) c[k] = c[k - 3];
        if (kind == 3) for (int k = 6; k < 9; k++) c[k] = c[k - 6];
        if (kind == 4) for (int k = 6; k < 9; k++) c[k] = c[k - 3];
        if (kind == 5) for (int k = 0; k < 3; k++) begin
            c[6 + k] = c[k] - (c[3 + k] - c[k]);
            if (c[6 + k] > 8388607 || c[6 + k] < -8388608) c[6 + k] = c[k];
        end
        return pack_pts(c);
    endfunction

    task automatic test_directed();
        int c[9];
        int pts[12][9] = '{
            '{0, 0, 0, 256, 0, 0, 0, 256, 0},
            '{0, 0, 0, 256, 0, 0, 256, 0, 0},
            '{0, 0, 0, 256, 0, 0, -256, 0, 0},
            '{0, 0, 0, 0, 0, 0, 100, 5, 7},
            '{1, 2, 3, 9, 9, 9, 1, 2, 3},
            '{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
              8388607, -8388608, 8388607},
            '{8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
              8388607, 8388607, -8388608},
            '{0, 0, 0, 1, 0, 0, -1, 1, 0},
            '{0, 0, 0, 1, 1, 1, 2, 2, 2},
            '{0, 0, 0, 1, 1, 1, -2, -2, -2},
            '{-8388608, 0, 0, 8388607, 0, 0, 8388607, 1, 0},
            '{5, 5, 5, 6, 5, 5, 5, 5, 6}
        };
        for (int i = 0; i < 12; i++) begin
            for (int k = 0; k < 9; k++) c[k] = pts[i][k];
            send_item(pack_pts(c));
        end
        // zero spacing on x makes an arm along x degenerate
        set_spacing(16'd0, 16'hFFFF, 16'd1);
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 9; k++) c[k] = pts[i][k];
            send_item(pack_pts(c));
        end
        wait_idle();
        write_spacing(CFG_UNUSED, 16'd7);
        send_item(pack_pts(pts[7]));
        send_item(pack_pts(pts[11]));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_item(random_item());
    endtask

    task automatic test_spacing_sweep();
        set_spacing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random(60);
        set_spacing(16'd1, 16'd4096, 16'hFFFF);
        test_random(60);
        set_spacing(SPACING_W'($urandom_range(0, 65535)), SPACING_W'($urandom_range(0, 65535)),
                    SPACING_W'($urandom_range(0, 65535)));
        test_random(60);
        set_spacing(16'd4096, 16'd0, 16'd2048);
        test_random(40);
    endtask

    task automatic test_backpressure();
        set_spacing(16'd4096, 16'd4096, 16'd4096);
        hold_cycles = 400;
        burst_left = 200;
        test_random(120);
    endtask

    initial begin
        spacing[0] = longint'(SPACING_RESET);
        spacing[1] = longint'(SPACING_RESET);
        spacing[2] = longint'(SPACING_RESET);
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(80);
        test_spacing_sweep();
        test_backpressure();
        wait_idle();
        $display("covered %0d transactions (%0d degenerate) over several spacing settings",
                 sent_count, degen_count);
        $display("including a long result stall; %0d mismatches", fail_count);
        if (fail_count == 0 && result_count == sent_count) begin
            $display("three_point_angle_3d test passed");
        end else begin
            $display("three_point_angle_3d test failed");
        end
        $finish;
    end

endmodule
